FILE: rtl/core/kmd_pkg.sv
// Shared types and constants for the keypad majority debouncer.
// Used by the sample cells, the vote unit, the top level and the checker.
// Depends on nothing.
package kmd_pkg;

    localparam int KEY_COUNT            = 4;
    localparam int PIN_W                = 5;
    localparam int PIN_WORD_W           = 32;
    localparam int CFG_INDEX_W          = 3;
    localparam int CFG_DATA_W           = 5;
    localparam int DEFAULT_SAMPLE_DEPTH = 8;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LATCH  = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_MASK   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIN_CANCEL = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIN_OK     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PIN_NORTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PIN_SOUTH  = 3'd4;

    // Control from the sequencer to the vote unit.
    typedef struct packed {
        logic clear;
        logic run;
    } vote_ctrl_t;

endpackage

FILE: rtl/core/keypad_majority_debouncer.sv
// Top level of the four-key majority-vote debouncer.
// Depends on kmd_pkg, kmd_cell and kmd_vote.
//
// A sample or query transfer yields its result in the cycle after it is
// accepted. A latch transfer first rotates the chain of sample cells one
// cell per cycle past the per-key vote counters (state S_LATCH), then
// applies the decision and registers the result (state S_VOTE), so the
// next transfer can follow once the block is back in S_IDLE. The input
// side takes a new transfer only when the block is between items and the
// output register is empty or being emptied. Configuration writes land at
// once and are meant for idle periods.
module keypad_majority_debouncer #(
    parameter int SAMPLE_DEPTH = kmd_pkg::DEFAULT_SAMPLE_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kmd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           operation,
    input  logic [kmd_pkg::PIN_WORD_W-1:0]       pin_word,
    input  logic [kmd_pkg::KEY_COUNT-1:0]        query_keys,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [kmd_pkg::KEY_COUNT-1:0]        keys_now,
    output logic [kmd_pkg::KEY_COUNT-1:0]        keys_changed,
    output logic                                 all_down
);

    localparam int KC    = kmd_pkg::KEY_COUNT;
    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SAMPLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LATCH = 3'b010,
        S_VOTE  = 3'b100
    } state_t;

    typedef struct packed {
        logic [KC-1:0] now;
        logic [KC-1:0] changed;
        logic          down;
    } result_t;

    function automatic result_t make_result(
        input logic [KC-1:0] latched,
        input logic [KC-1:0] previous,
        input logic [KC-1:0] query,
        input logic [KC-1:0] mask
    );
        result_t       r;
        logic [KC-1:0] q;
        q         = query & mask;
        r.now     = latched & mask;
        r.changed = (previous ^ latched) & q;
        r.down    = ((latched & q) == q);
        return r;
    endfunction

    state_t                   state_reg, state_next;
    logic [KC-1:0]            key_mask_reg;
    logic [kmd_pkg::PIN_W-1:0] pin_reg [KC];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [KC-1:0]            latched_reg, latched_next;
    logic [KC-1:0]            previous_reg, previous_next;
    logic                     out_valid_reg, out_valid_next;
    logic [KC-1:0]            query_reg;
    result_t                  result_reg;

    logic                     in_accept;
    logic                     load_result;
    logic                     shift_en;
    logic                     rotate;
    logic [KC-1:0]            sample_bits;
    logic [KC-1:0]            chain_head;
    logic [KC-1:0]            cell_q [SAMPLE_DEPTH];
    kmd_pkg::vote_ctrl_t      vote_ctrl;
    logic                     vote_last;
    logic [KC-1:0]            vote_keys;
    result_t                  result;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    // Pins are active low, so a key is down when its pin reads zero.
    always_comb
    begin
        for (int k = 0; k < KC; k++)
        begin
            sample_bits[k] = ~pin_word[pin_reg[k]];
        end
    end

    assign chain_head = rotate ? cell_q[SAMPLE_DEPTH-1] : sample_bits;

    for (genvar j = 0; j < SAMPLE_DEPTH; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            kmd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (chain_head),
                .q        (cell_q[j])
            );
        end
        else
        begin : g_body
            kmd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[j-1]),
                .q        (cell_q[j])
            );
        end
    end

    kmd_vote #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_vote (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (vote_ctrl),
        .tail         (cell_q[SAMPLE_DEPTH-1]),
        .sample_count (count_reg),
        .last         (vote_last),
        .keys         (vote_keys)
    );

    always_comb
    begin
        if (state_reg == S_VOTE)
        begin
            result = make_result(vote_keys, latched_reg, query_reg, key_mask_reg);
        end
        else
        begin
            result = make_result(latched_reg, previous_reg, query_keys, key_mask_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        latched_next   = latched_reg;
        previous_next  = previous_reg;
        load_result    = 1'b0;
        shift_en       = 1'b0;
        rotate         = 1'b0;
        vote_ctrl      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        kmd_pkg::OP_SAMPLE:
                        begin
                            shift_en    = 1'b1;
                            load_result = 1'b1;
                            if (count_reg != DEPTH_CNT)
                            begin
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        kmd_pkg::OP_LATCH:
                        begin
                            vote_ctrl.clear = 1'b1;
                            state_next      = S_LATCH;
                        end
                        default:
                        begin
                            load_result = 1'b1;
                        end
                    endcase
                end
            end
            S_LATCH:
            begin
                vote_ctrl.run = 1'b1;
                shift_en      = 1'b1;
                rotate        = 1'b1;
                if (vote_last)
                begin
                    state_next = S_VOTE;
                end
            end
            S_VOTE:
            begin
                latched_next  = vote_keys;
                previous_next = latched_reg;
                count_next    = '0;
                load_result   = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = load_result || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_mask_reg  <= 4'hF;
            pin_reg[0]    <= 5'd0;
            pin_reg[1]    <= 5'd1;
            pin_reg[2]    <= 5'd2;
            pin_reg[3]    <= 5'd3;
            count_reg     <= '0;
            latched_reg   <= '0;
            previous_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kmd_pkg::REG_KEY_MASK:   key_mask_reg <= cfg_data[KC-1:0];
                    kmd_pkg::REG_PIN_CANCEL: pin_reg[0]   <= cfg_data;
                    kmd_pkg::REG_PIN_OK:     pin_reg[1]   <= cfg_data;
                    kmd_pkg::REG_PIN_NORTH:  pin_reg[2]   <= cfg_data;
                    kmd_pkg::REG_PIN_SOUTH:  pin_reg[3]   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg     <= state_next;
            count_reg     <= count_next;
            latched_reg   <= latched_next;
            previous_reg  <= previous_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            query_reg <= query_keys;
        end
        if (load_result)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign keys_now     = result_reg.now;
    assign keys_changed = result_reg.changed;
    assign all_down     = result_reg.down;

endmodule

FILE: rtl/core/kmd_cell.sv
// One storage cell of the sample chain: holds one key vector.
// Loads from its left neighbor whenever the chain shifts.
// Depends on kmd_pkg.
module kmd_cell
(
    input  logic                            clk,
    input  logic                            shift_en,
    input  logic [kmd_pkg::KEY_COUNT-1:0]   d,
    output logic [kmd_pkg::KEY_COUNT-1:0]   q
);

    logic [kmd_pkg::KEY_COUNT-1:0] sample_reg;
    logic [kmd_pkg::KEY_COUNT-1:0] sample_next;

    always_comb
    begin
        sample_next = shift_en ? d : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

FILE: rtl/core/kmd_vote.sv
// Vote unit: counts ones per key at the tail of the rotating sample chain
// and forms the majority decision. Depends on kmd_pkg.
module kmd_vote #(
    parameter int SAMPLE_DEPTH = kmd_pkg::DEFAULT_SAMPLE_DEPTH
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  kmd_pkg::vote_ctrl_t                      ctrl,
    input  logic [kmd_pkg::KEY_COUNT-1:0]            tail,
    input  logic [$clog2(SAMPLE_DEPTH+1)-1:0]        sample_count,
    output logic                                     last,
    output logic [kmd_pkg::KEY_COUNT-1:0]            keys
);

    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SAMPLE_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(SAMPLE_DEPTH);

    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic [CNT_W-1:0] ones_reg  [kmd_pkg::KEY_COUNT];
    logic [CNT_W-1:0] ones_next [kmd_pkg::KEY_COUNT];
    logic             tail_valid;

    // At step i the tail holds the cell that sat i places from the end.
    // Only the newest sample_count cells were written since the last latch.
    assign tail_valid = ({1'b0, step_reg} + {1'b0, sample_count}) >= DEPTH_EXT;
    assign last       = (step_reg == LAST_STEP);

    always_comb
    begin
        step_next = step_reg;
        for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
        begin
            ones_next[k] = ones_reg[k];
        end
        if (ctrl.clear)
        begin
            step_next = '0;
            for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
            begin
                ones_next[k] = '0;
            end
        end
        else if (ctrl.run)
        begin
            step_next = CNT_W'(step_reg + 1'b1);
            for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
            begin
                ones_next[k] = CNT_W'(ones_reg[k] + {{(CNT_W-1){1'b0}},
                                                     (tail_valid & tail[k])});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
            begin
                ones_reg[k] <= '0;
            end
        end
        else
        begin
            step_reg <= step_next;
            for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
            begin
                ones_reg[k] <= ones_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < kmd_pkg::KEY_COUNT; k++)
        begin
            keys[k] = {ones_reg[k], 1'b0} > {1'b0, sample_count};
        end
    end

endmodule

FILE: rtl/core/kmd_checker.sv
// Port-level checker for the keypad majority debouncer, bound to the top.
// Depends on kmd_pkg and keypad_majority_debouncer.
module kmd_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic [1:0]                           operation,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [kmd_pkg::KEY_COUNT-1:0]        keys_now,
    input logic [kmd_pkg::KEY_COUNT-1:0]        keys_changed,
    input logic                                 all_down
);

    // A stalled result blocks new input transfers.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while a result is stalled");

    // Sample and query transfers produce their result on the next cycle.
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation != kmd_pkg::OP_LATCH)) |=> out_valid)
        else $error("missing result after sample or query transfer");

    // A latch transfer keeps the block busy and shows no result at once.
    a_latch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == kmd_pkg::OP_LATCH))
            |=> (!out_valid && !in_ready))
        else $error("latch did not hold the block busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(keys_now)
            && $stable(keys_changed) && $stable(all_down)))
        else $error("stalled result changed");

endmodule

bind keypad_majority_debouncer kmd_checker u_kmd_checker (.*);
